[hw/rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// Sequential list engine package
// Sizes, opcodes, status codes and the structs shared by the list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY   = 128;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 8;
  localparam int VAL_W      = 32;
  localparam int OUT_CNT_W  = 8;
  // compare width: holds any count, position or pointer
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_BACK  = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [VAL_W-1:0]     item_out;
    logic [OUT_CNT_W-1:0] item_count;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the command word
    logic ptr_init;  // pointer to count (insert) or position (remove)
    logic rd_at;     // read entry at the target position
    logic rd_up;     // read entry below the pointer
    logic rd_dn;     // read entry above the pointer
    logic wr_up;     // write read data at pointer, step down
    logic wr_dn;     // write read data at pointer, step up
    logic wr_ins;    // write new item at the target position
    logic cap_item;  // capture read data as the returned item
    logic commit;    // update count, present the result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic err;
    logic is_ins;
    logic is_read;
    logic is_clear;
    logic up_more;
    logic dn_more;
  } stat_t;

endpackage

[hw/rtl/sequential_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of up to CAPACITY items in a RAM, one opcode per command word.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its result
// word appears on res_o for exactly one cycle with done_o high, and must be
// taken then, since the engine cannot hold it. Every command yields one
// result. Items live in a single-port-read, single-port-write RAM, so
// shifting the list moves one entry at a time, a read state then a write
// state per entry. busy stays high for the whole operation and drops in
// the cycle the result is shown, so the next command may be given in that
// cycle.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sle_pkg::cmd_t     cmd_i,
  output logic              done_o,
  output sle_pkg::result_t  res_o
);
  import sle_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  sle_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cmd_i  (cmd_i),
    .stat_o (stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

[hw/rtl/sle_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sle_datapath.sv]
// ----------------------------------------------------------------------------
// List engine datapath
// Command register, fill count, shift pointer, list RAM and result register.
// ----------------------------------------------------------------------------
module sle_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sle_pkg::ctrl_t    ctrl_i,
  input  sle_pkg::cmd_t     cmd_i,
  output sle_pkg::stat_t    stat_o,
  output logic              done_o,
  output sle_pkg::result_t  res_o
);
  import sle_pkg::*;

  logic [2:0]            op_q;
  logic [POS_W-1:0]      pos_q;
  logic [ITEM_WIDTH-1:0] val_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CMP_W-1:0]      ptr_q, ptr_d;
  logic                  done_q;
  result_t               res_q, res_d;

  logic [CMP_W-1:0]      count_w, at_w, ptr_up_w, ptr_dn_w, raddr_w, waddr_w;
  logic                  is_ins, is_rem, is_read, is_clear, err;
  logic [1:0]            status_c;
  logic                  ram_re, ram_we;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  assign count_w  = CMP_W'(count_q);
  assign ptr_up_w = ptr_q + CMP_W'(1);
  assign ptr_dn_w = ptr_q - CMP_W'(1);

  assign is_ins   = (op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK) || (op_q == OP_INS_AT);
  assign is_rem   = (op_q == OP_REM_FRONT) || (op_q == OP_REM_BACK) || (op_q == OP_REM_AT);
  assign is_read  = (op_q == OP_READ);
  assign is_clear = (op_q == OP_CLEAR);

  always_comb begin
    case (op_q)
      OP_INS_FRONT, OP_REM_FRONT: at_w = '0;
      OP_INS_BACK:                at_w = count_w;
      OP_REM_BACK:                at_w = count_w - CMP_W'(1);
      default:                    at_w = CMP_W'(pos_q);
    endcase
  end

  // full is checked before position on inserts
  always_comb begin
    status_c = ST_OK;
    if (is_ins) begin
      if (count_w >= CMP_W'(CAPACITY)) begin
        status_c = ST_FULL;
      end else if (at_w > count_w) begin
        status_c = ST_BADPOS;
      end
    end else if (is_rem || is_read) begin
      if (count_q == '0) begin
        status_c = ST_EMPTY;
      end else if (at_w >= count_w) begin
        status_c = ST_BADPOS;
      end
    end
  end

  assign err = (status_c != ST_OK);

  assign stat_o.err      = err;
  assign stat_o.is_ins   = is_ins;
  assign stat_o.is_read  = is_read;
  assign stat_o.is_clear = is_clear;
  assign stat_o.up_more  = (ptr_q > at_w);
  assign stat_o.dn_more  = (ptr_up_w < count_w);

  always_comb begin
    count_d = count_q;
    if (is_clear) begin
      count_d = '0;
    end else if (!err && is_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (!err && is_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.ptr_init) begin
      ptr_d = is_ins ? count_w : at_w;
    end else if (ctrl_i.wr_up) begin
      ptr_d = ptr_dn_w;
    end else if (ctrl_i.wr_dn) begin
      ptr_d = ptr_up_w;
    end
  end

  // list RAM ports
  assign ram_re    = ctrl_i.rd_at || ctrl_i.rd_up || ctrl_i.rd_dn;
  assign raddr_w   = ctrl_i.rd_at ? at_w : (ctrl_i.rd_up ? ptr_dn_w : ptr_up_w);
  assign ram_we    = ctrl_i.wr_up || ctrl_i.wr_dn || ctrl_i.wr_ins;
  assign waddr_w   = ctrl_i.wr_ins ? at_w : ptr_q;
  assign ram_wdata = ctrl_i.wr_ins ? val_q : ram_rdata;

  sle_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_w[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr_w[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_d.status     = status_c;
    res_d.item_out   = VAL_W'(item_q);
    res_d.item_count = OUT_CNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      done_q <= ctrl_i.commit;
      if (ctrl_i.commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q   <= cmd_i.opcode;
      pos_q  <= cmd_i.position;
      val_q  <= ITEM_WIDTH'(cmd_i.item_value);
      item_q <= '0;
    end else if (ctrl_i.cap_item) begin
      item_q <= ram_rdata;
    end
    if (ctrl_i.commit) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_done_follows_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |=> done_q)
    else $error("result strobe missing after commit");

  a_fail_no_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status != ST_OK)) |-> (res_q.item_out == '0))
    else $error("failed request returned an item");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

[hw/rtl/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// List engine controller
// Sequences check, shift sweep, item write or read, and result commit.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sle_pkg::stat_t  stat_i,
  output sle_pkg::ctrl_t  ctrl_o
);
  import sle_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_WR   = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_RD_WAIT = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_WR   = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.err || stat_i.is_clear) begin
          state_d = S_FINISH;
        end else if (stat_i.is_ins) begin
          ctrl_o.ptr_init = 1'b1;
          state_d         = S_UP_RD;
        end else begin
          ctrl_o.ptr_init = 1'b1;
          ctrl_o.rd_at    = 1'b1;
          state_d         = S_RD_WAIT;
        end
      end
      // open a slot: move entries up one at a time from the tail
      S_UP_RD: begin
        if (stat_i.up_more) begin
          ctrl_o.rd_up = 1'b1;
          state_d      = S_UP_WR;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_UP_WR: begin
        ctrl_o.wr_up = 1'b1;
        state_d      = S_UP_RD;
      end
      S_INS_WR: begin
        ctrl_o.wr_ins = 1'b1;
        state_d       = S_FINISH;
      end
      S_RD_WAIT: begin
        ctrl_o.cap_item = 1'b1;
        state_d         = stat_i.is_read ? S_FINISH : S_DN_RD;
      end
      // close the gap: move entries down toward the removed slot
      S_DN_RD: begin
        if (stat_i.dn_more) begin
          ctrl_o.rd_dn = 1'b1;
          state_d      = S_DN_WR;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DN_WR: begin
        ctrl_o.wr_dn = 1'b1;
        state_d      = S_DN_RD;
      end
      S_FINISH: begin
        ctrl_o.commit = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

[verif/sle_list_checker.sv]
// ----------------------------------------------------------------------------
// Sequential list engine checker
// Watches the command and result channels of the list engine. It keeps a
// mirror of the list, predicts the result word of every accepted command and
// compares each result word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sle_list_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  sle_pkg::cmd_t     cmd_i,
  input  logic              done_i,
  input  sle_pkg::result_t  res_i,
  output int                mismatch_count_o,
  output int                pending_words_o,
  output int                fill_level_o,
  output int                results_checked_o
);
  import sle_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MASK = {VAL_W{1'b1}} >> (VAL_W - ITEM_WIDTH);

  logic [VAL_W-1:0] list_mirror [CAPACITY];
  int               mirror_count;
  result_t          predicted_results [$];
  result_t          want;
  int               mismatches;
  int               checked;

  // Applies one command to the mirror and returns the result word it yields.
  function automatic result_t apply_list_op(cmd_t c);
    result_t          r;
    int               at;
    logic [VAL_W-1:0] v;
    r = '0;
    r.status = ST_OK;
    v = c.item_value & VAL_MASK;
    case (c.opcode)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (mirror_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (c.opcode == OP_INS_FRONT) at = 0;
          else if (c.opcode == OP_INS_BACK) at = mirror_count;
          else at = int'(c.position);
          if (at > mirror_count) begin
            r.status = ST_BADPOS;
          end else begin
            for (int i = mirror_count; i > at; i--) list_mirror[i] = list_mirror[i-1];
            list_mirror[at] = v;
            mirror_count++;
          end
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT, OP_READ: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.opcode == OP_REM_FRONT) at = 0;
          else if (c.opcode == OP_REM_BACK) at = mirror_count - 1;
          else at = int'(c.position);
          if (at >= mirror_count) begin
            r.status = ST_BADPOS;
          end else begin
            r.item_out = list_mirror[at];
            if (c.opcode != OP_READ) begin
              mirror_count--;
              for (int i = at; i < mirror_count; i++) list_mirror[i] = list_mirror[i+1];
            end
          end
        end
      end
      default: begin
        mirror_count = 0;
      end
    endcase
    r.item_count = OUT_CNT_W'(mirror_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_results.delete();
      foreach (list_mirror[i]) list_mirror[i] = '0;
      mirror_count = 0;
      mismatches = 0;
      checked = 0;
      mismatch_count_o <= 0;
      pending_words_o <= 0;
      fill_level_o <= 0;
      results_checked_o <= 0;
    end else begin
      // result first: a word accepted at this edge cannot have answered yet
      if (done_i) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d item %08h count %0d",
                     res_i.status, res_i.item_out, res_i.item_count);
        end else begin
          want = predicted_results.pop_front();
          checked++;
          if (res_i.status !== want.status || res_i.item_out !== want.item_out ||
              res_i.item_count !== want.item_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: status %0d/%0d item %08h/%08h count %0d/%0d (exp/got)",
                       checked, want.status, res_i.status, want.item_out, res_i.item_out,
                       want.item_count, res_i.item_count);
          end
        end
      end
      if (start_i && !busy_i) predicted_results.push_back(apply_list_op(cmd_i));
      mismatch_count_o <= mismatches;
      pending_words_o <= predicted_results.size();
      fill_level_o <= mirror_count;
      results_checked_o <= checked;
    end
  end

endmodule

[verif/sequential_list_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives directed and phased random command words into the list engine
// with random gaps; a checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int RAND_ITEMS = 830;
  localparam int IDLE_LIMIT = 2000;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t res;

  int mismatch_count;
  int pending_words;
  int fill_level;
  int results_checked;

  int issued;
  int burst_left;
  int idle_cycles;

  sequential_list_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd),
    .done_o (done),
    .res_o  (res)
  );

  sle_list_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .cmd_i             (cmd),
    .done_i            (done),
    .res_i             (res),
    .mismatch_count_o  (mismatch_count),
    .pending_words_o   (pending_words),
    .fill_level_o      (fill_level),
    .results_checked_o (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // stall watchdog: no command taken and no result seen for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d words pending", pending_words);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [POS_W-1:0] pos,
                                    logic [VAL_W-1:0] val);
    cmd_t c;
    c.opcode = op;
    c.position = pos;
    c.item_value = val;
    return c;
  endfunction

  // weighted opcode draw: inserts, removes, reads, clears
  function automatic logic [2:0] pick_op(int ins_w, int rem_w, int rd_w, int clr_w);
    int r;
    r = $urandom_range(0, ins_w + rem_w + rd_w + clr_w - 1);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_FRONT;
        1:       return OP_INS_BACK;
        default: return OP_INS_AT;
      endcase
    end
    if (r < ins_w + rem_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_REM_FRONT;
        1:       return OP_REM_BACK;
        default: return OP_REM_AT;
      endcase
    end
    if (r < ins_w + rem_w + rd_w) return OP_READ;
    return OP_CLEAR;
  endfunction

  // mostly in range, some boundaries, some anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos(int fill);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return POS_W'($urandom_range(0, fill));
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return POS_W'(fill);
        2:       return POS_W'(CAPACITY - 1);
        3:       return POS_W'(CAPACITY);
        default: return '1;
      endcase
    end
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VAL_W-1:0] pick_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom());
  endfunction

  // Presents one command word after a random gap and returns on the edge
  // that takes it.
  task automatic issue(cmd_t c);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  initial begin
    phase_e     phase;
    int         stay;
    int         mixed_left;
    int         full_reached;
    logic [2:0] op;

    start = 1'b0;
    cmd = '0;
    rst_ni = 1'b0;
    issued = 0;
    burst_left = 0;
    phase = PH_GROW;
    stay = 0;
    mixed_left = 0;
    full_reached = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, boundary positions, append at count, clear
    issue(make_cmd(OP_CLEAR, 8'd0, 32'h0));
    issue(make_cmd(OP_READ, 8'd0, 32'h0));
    issue(make_cmd(OP_REM_FRONT, 8'd0, 32'h0));
    issue(make_cmd(OP_REM_BACK, 8'd0, 32'h0));
    issue(make_cmd(OP_REM_AT, 8'd0, 32'h0));
    issue(make_cmd(OP_INS_AT, 8'd1, 32'h1234_5678));
    issue(make_cmd(OP_INS_AT, 8'd0, 32'h0000_0000));
    issue(make_cmd(OP_INS_BACK, 8'd255, 32'hFFFF_FFFF));
    issue(make_cmd(OP_INS_FRONT, 8'd7, 32'hA5A5_A5A5));
    issue(make_cmd(OP_INS_AT, 8'd3, 32'h5A5A_5A5A));
    issue(make_cmd(OP_INS_AT, 8'd5, 32'hDEAD_BEEF));
    issue(make_cmd(OP_READ, 8'd0, 32'hFFFF_FFFF));
    issue(make_cmd(OP_READ, 8'd3, 32'h0));
    issue(make_cmd(OP_READ, 8'd4, 32'h0));
    issue(make_cmd(OP_READ, 8'd255, 32'h0));
    issue(make_cmd(OP_REM_AT, 8'd1, 32'h0));
    issue(make_cmd(OP_REM_AT, 8'd3, 32'h0));
    issue(make_cmd(OP_REM_FRONT, 8'd0, 32'h0));
    issue(make_cmd(OP_REM_BACK, 8'd128, 32'h0));
    issue(make_cmd(OP_INS_AT, 8'd255, 32'hCAFE_F00D));
    issue(make_cmd(OP_INS_AT, 8'd128, 32'h8000_0001));
    issue(make_cmd(OP_CLEAR, 8'd255, 32'hFFFF_FFFF));
    issue(make_cmd(OP_READ, 8'd0, 32'h0));

    // random: fill to capacity, drain to empty, then a mixed stretch
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (phase)
        PH_GROW: begin
          op = pick_op(80, 8, 10, 0);
          if (fill_level >= CAPACITY) begin
            if (stay == 0) full_reached++;
            stay++;
          end
          if (stay > 5) begin
            stay = 0;
            if ($urandom_range(0, 3) == 0) op = OP_CLEAR;
            else phase = PH_SHRINK;
          end
        end
        PH_SHRINK: begin
          op = pick_op(10, 75, 15, 0);
          if (fill_level == 0) stay++;
          if (stay > 4) begin
            stay = 0;
            phase = PH_MIXED;
            mixed_left = $urandom_range(20, 60);
          end
        end
        default: begin
          op = pick_op(40, 40, 15, 5);
          mixed_left--;
          if (mixed_left <= 0) phase = PH_GROW;
        end
      endcase
      issue(make_cmd(op, pick_pos(fill_level), pick_val()));
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("%0d command words issued, %0d result words checked", issued, results_checked);
    $display("list driven to capacity %0d times, %0d mismatches", full_reached,
             mismatch_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
